// File: rtl/core/i2cm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, sequence step codes and constants of the I2C master byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  // Command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Sequence step codes
  localparam int          STEP_W    = 5;
  localparam logic [4:0]  ST_IDLE   = 5'd0;
  localparam logic [4:0]  ST_S1     = 5'd1;
  localparam logic [4:0]  ST_S2     = 5'd2;
  localparam logic [4:0]  ST_S3     = 5'd3;
  localparam logic [4:0]  ST_P1     = 5'd4;
  localparam logic [4:0]  ST_P2     = 5'd5;
  localparam logic [4:0]  ST_P3     = 5'd6;
  localparam logic [4:0]  ST_WHI    = 5'd7;
  localparam logic [4:0]  ST_WLO    = 5'd8;
  localparam logic [4:0]  ST_A1     = 5'd9;
  localparam logic [4:0]  ST_A2     = 5'd10;
  localparam logic [4:0]  ST_A3     = 5'd11;
  localparam logic [4:0]  ST_RPRE   = 5'd12;
  localparam logic [4:0]  ST_RHI    = 5'd13;
  localparam logic [4:0]  ST_RLO    = 5'd14;
  localparam logic [4:0]  ST_RGAP   = 5'd15;
  localparam logic [4:0]  ST_K1     = 5'd16;
  localparam logic [4:0]  ST_K2     = 5'd17;
  localparam logic [4:0]  ST_K3     = 5'd18;

  localparam logic [7:0]  MSB_MASK        = 8'h80;
  localparam logic [3:0]  LAST_BIT        = 4'd7;
  localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;
  localparam logic [15:0] PHASE_TICKS_RST = 16'd2;
  localparam int          QUEUE_DEPTH_DEF = 2;

  // One input item
  typedef struct packed {
    logic       tick;
    logic       command_valid;
    logic [1:0] command;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       ready_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       nack_seen;
  } res_item_t;

  // Classified item, as held in the queue
  typedef struct packed {
    logic             tick;
    logic             load;
    logic [STEP_W-1:0] first_step;
    logic             set_scl;
    logic             scl_val;
    logic             set_sda;
    logic             sda_val;
    logic             set_shift;
    logic [7:0]       shift_val;
    logic             set_ack;
    logic             ack_val;
    logic             sda_in;
  } op_t;

  // Queue status toward the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// File: rtl/core/i2cm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts input items and classifies any command into its first-phase setup.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_front (
  input  wire                  item_valid,
  output logic                 item_ready,
  input  i2cm_pkg::in_item_t   item,
  input  i2cm_pkg::q_status_t  q_status,
  output logic                 push,
  output i2cm_pkg::op_t        op
);
  import i2cm_pkg::*;

  assign item_ready = !q_status.full;
  assign push       = item_valid && !q_status.full;

  always_comb begin
    op            = '0;
    op.tick       = item.tick;
    op.load       = item.command_valid;
    op.sda_in     = item.sda_in;
    op.shift_val  = item.write_byte;
    op.ack_val    = item.send_ack;
    unique case (item.command)
      CMD_START: begin
        op.first_step = ST_S1;
        op.set_scl    = 1'b1;
        op.scl_val    = 1'b1;
        op.set_sda    = 1'b1;
        op.sda_val    = 1'b1;
      end
      CMD_STOP: begin
        op.first_step = ST_P1;
        op.set_scl    = 1'b1;
        op.scl_val    = 1'b0;
      end
      CMD_WRITE: begin
        op.first_step = ST_WHI;
        op.set_scl    = 1'b1;
        op.scl_val    = 1'b1;
        op.set_sda    = 1'b1;
        op.sda_val    = |(item.write_byte & MSB_MASK);
        op.set_shift  = 1'b1;
      end
      default: begin
        op.first_step = ST_RPRE;
        op.set_sda    = 1'b1;
        op.sda_val    = 1'b1;
        op.set_shift  = 1'b1;
        op.shift_val  = 8'h00;
        op.set_ack    = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/i2cm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_queue
// Short FIFO of classified items between the front and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_queue #(
  parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  i2cm_pkg::op_t        push_op,
  input  wire                  pop,
  output i2cm_pkg::op_t        head,
  output i2cm_pkg::q_status_t  status
);
  import i2cm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  op_t              slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] level;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (level == FULL_CNT);
  assign status.empty = (level == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        level <= level + 1'b1;
      end else if (do_pop && !do_push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/i2cm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_seq
// Phase sequencer: runs one queued item per cycle into the result register, unless a pending result is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_seq (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire  [15:0]          cfg_data,
  input  i2cm_pkg::op_t        head,
  input  i2cm_pkg::q_status_t  q_status,
  output logic                 pop,
  output logic                 result_valid,
  input  wire                  result_ready,
  output i2cm_pkg::res_item_t  result
);
  import i2cm_pkg::*;

  logic [15:0]       phase_ticks;
  logic [STEP_W-1:0] step, step_next;
  logic [15:0]       phase_cnt, phase_cnt_next;
  logic [3:0]        bit_cnt, bit_cnt_next;
  logic [7:0]        shreg, shreg_next;
  logic              ack_choice, ack_choice_next;
  logic              nack_flag, nack_flag_next;
  logic              scl, scl_next;
  logic              sda, sda_next;
  logic [7:0]        read_hold, read_hold_next;
  logic              done;

  logic [15:0] limit;
  logic [16:0] cnt_inc;
  logic [3:0]  bit_inc;

  assign pop     = !q_status.empty && (!result_valid || result_ready);
  assign limit   = (phase_ticks == '0) ? 16'd1 : phase_ticks;
  assign cnt_inc = {1'b0, phase_cnt} + 17'd1;
  assign bit_inc = bit_cnt + 4'd1;

  always_comb begin
    step_next       = step;
    phase_cnt_next  = phase_cnt;
    bit_cnt_next    = bit_cnt;
    shreg_next      = shreg;
    ack_choice_next = ack_choice;
    nack_flag_next  = nack_flag;
    scl_next        = scl;
    sda_next        = sda;
    read_hold_next  = read_hold;
    done            = 1'b0;
    if (step == ST_IDLE) begin
      if (head.load) begin
        phase_cnt_next = '0;
        bit_cnt_next   = '0;
        step_next      = head.first_step;
        if (head.set_scl)   scl_next        = head.scl_val;
        if (head.set_sda)   sda_next        = head.sda_val;
        if (head.set_shift) shreg_next      = head.shift_val;
        if (head.set_ack)   ack_choice_next = head.ack_val;
      end
    end else if (head.tick) begin
      phase_cnt_next = cnt_inc[15:0];
      if (cnt_inc >= {1'b0, limit}) begin
        phase_cnt_next = '0;
        unique case (step)
          ST_S1: begin sda_next = 1'b0; step_next = ST_S2; end
          ST_S2: begin scl_next = 1'b0; step_next = ST_S3; end
          ST_S3: begin step_next = ST_IDLE; done = 1'b1; end
          ST_P1: begin sda_next = 1'b0; step_next = ST_P2; end
          ST_P2: begin scl_next = 1'b1; step_next = ST_P3; end
          ST_P3: begin sda_next = 1'b1; step_next = ST_IDLE; done = 1'b1; end
          ST_WHI: begin
            scl_next = 1'b0;
            if (bit_cnt == LAST_BIT) sda_next = 1'b1;
            shreg_next = {shreg[6:0], 1'b0};
            step_next  = ST_WLO;
          end
          ST_WLO: begin
            bit_cnt_next = bit_inc;
            if (bit_inc < BITS_PER_BYTE) begin
              sda_next  = |(shreg & MSB_MASK);
              scl_next  = 1'b1;
              step_next = ST_WHI;
            end else begin
              sda_next  = 1'b1;
              step_next = ST_A1;
            end
          end
          ST_A1: begin scl_next = 1'b1; step_next = ST_A2; end
          ST_A2: begin
            nack_flag_next = head.sda_in;
            scl_next       = 1'b0;
            step_next      = ST_A3;
          end
          ST_A3: begin step_next = ST_IDLE; done = 1'b1; end
          ST_RPRE: begin scl_next = 1'b1; step_next = ST_RHI; end
          ST_RHI: begin
            shreg_next = {shreg[6:0], head.sda_in};
            scl_next   = 1'b0;
            step_next  = ST_RLO;
          end
          ST_RLO: begin
            bit_cnt_next = bit_inc;
            if (bit_inc < BITS_PER_BYTE) begin
              scl_next  = 1'b1;
              step_next = ST_RHI;
            end else begin
              step_next = ST_RGAP;
            end
          end
          ST_RGAP: begin sda_next = !ack_choice; step_next = ST_K1; end
          ST_K1: begin scl_next = 1'b1; step_next = ST_K2; end
          ST_K2: begin scl_next = 1'b0; step_next = ST_K3; end
          ST_K3: begin
            if (ack_choice) sda_next = 1'b1;
            read_hold_next = shreg;
            step_next      = ST_IDLE;
            done           = 1'b1;
          end
          default: step_next = ST_IDLE;  // stray code: back to idle, no done
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RST;
    end else if (cfg_we) begin
      phase_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= ST_IDLE;
      phase_cnt    <= '0;
      bit_cnt      <= '0;
      shreg        <= '0;
      ack_choice   <= 1'b0;
      nack_flag    <= 1'b0;
      scl          <= 1'b1;
      sda          <= 1'b1;
      read_hold    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        step         <= step_next;
        phase_cnt    <= phase_cnt_next;
        bit_cnt      <= bit_cnt_next;
        shreg        <= shreg_next;
        ack_choice   <= ack_choice_next;
        nack_flag    <= nack_flag_next;
        scl          <= scl_next;
        sda          <= sda_next;
        read_hold    <= read_hold_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.scl_level <= scl_next;
      result.sda_level <= sda_next;
      result.ready_res <= (step_next == ST_IDLE);
      result.done_res  <= done;
      result.read_data <= read_hold_next;
      result.nack_seen <= nack_flag_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/i2c_master_byte_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master bit sequencer: start, stop, write byte and read byte commands.
// ----------------------------------------------------------------------------
// Usage:
//   Every input item is one time slot: a tick flag, an optional command
//   (taken only when the engine is idle), the byte/ack choice and the sampled
//   SDA level. Each accepted item yields exactly one result item with the
//   SCL/SDA drive levels, ready, done pulse, last read byte and NACK flag.
//   Channels are valid/ready; cfg_we/cfg_data write phase_ticks (ticks per
//   phase, 0 acts as 1) and should only be written while idle.
//   Throughput: one item per cycle while results are taken. An accepted
//   item is written into a queue slot, then into the sequencer's result
//   register. The sequencer advances at most one phase per item.
//   When the receiver stalls, the result register holds and the queue
//   between the classifier and the sequencer fills; item_ready drops once it
//   is full, and is high again right after the edge at which a result is
//   taken.
//   Reset (rst, synchronous): queue empty, no result pending, sequencer idle,
//   both lines released high, phase_ticks = 2, read byte and NACK cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine #(
  parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  item_valid,
  output logic                 item_ready,
  input  i2cm_pkg::in_item_t   item,
  output logic                 result_valid,
  input  wire                  result_ready,
  output i2cm_pkg::res_item_t  result,
  input  wire                  cfg_we,
  input  wire  [15:0]          cfg_data
);
  import i2cm_pkg::*;

  q_status_t q_status;
  op_t       push_op;
  op_t       head;
  logic      push;
  logic      pop;

  // Front: accept and classify the command into its first phase
  i2cm_front u_front (
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_status   (q_status),
    .push       (push),
    .op         (push_op)
  );

  // Decoupling queue
  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .status  (q_status)
  );

  // Back: phase sequencer and result register
  i2cm_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // A full queue only happens behind a stalled result
  a_full_implies_pending: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid)
    else $error("queue full with no result pending");

  // A command finishes only into the idle state
  a_done_is_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.done_res) |-> result.ready_res)
    else $error("done without ready");

  // A pop always loads the result register
  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    pop |=> result_valid)
    else $error("popped item lost");

  // Sequencer never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: tb/i2c_master_byte_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_tb
// Self-checking bench for the I2C master byte engine. Every item sent in
// (tick, optional command, sampled SDA) is run through a cycle-exact model of
// the bit sequencer, and each result item coming back is compared field by
// field against the oldest predicted bus state. Directed command runs come
// first, then phase_ticks sweeps, random transaction traffic under four
// idling mixes and a long output hold-off.
// ----------------------------------------------------------------------------

module i2c_master_byte_engine_tb;
  import i2cm_pkg::*;

  localparam int MAX_SHOWN   = 30;   // mismatch lines printed, all are counted
  localparam int TAIL_CYCLES = 16;   // quiet cycles after the last result

  typedef enum {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_mode_e;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  in_item_t    item;
  logic        result_valid;
  logic        result_ready;
  res_item_t   result;
  logic        cfg_we;
  logic [15:0] cfg_data;

  i2c_master_byte_engine u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  // Line model state, advanced once per accepted item
  logic [4:0]  mdl_step;
  logic [15:0] mdl_count;
  logic [3:0]  mdl_bits;
  logic [7:0]  mdl_shift;
  logic [1:0]  mdl_cmd;
  logic        mdl_ack;
  logic        mdl_nack;
  logic        mdl_scl;
  logic        mdl_sda;
  logic [7:0]  mdl_rd_hold;
  logic [15:0] mdl_ticks;

  res_item_t   expected_lines[$];

  // Idling knobs: gap and stall percent per cycle, and a requested output hold-off
  int tx_gap_pct;
  int rx_stall_pct;
  int hold_req;

  int mismatch_count;
  int items_sent;
  int results_checked;
  int busy_cmds;
  int in_stall_cycles;
  int cmd_count[4];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run guard: well past the slowest legal run
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN)
      $display("MISMATCH %s: got 0x%0h expected 0x%0h (result %0d, t=%0t)",
               field, got, want, results_checked, $realtime);
  endtask

  // Predicts the bus state after one item. Commands only land while idle;
  // the accept cycle itself never counts a tick.
  task automatic step_line_model(input in_item_t it, output res_item_t r);
    logic [15:0] limit;
    logic        done;
    limit = (mdl_ticks == 16'd0) ? 16'd1 : mdl_ticks;   // zero acts as one
    done  = 1'b0;
    if (mdl_step == ST_IDLE) begin
      if (it.command_valid) begin
        mdl_cmd   = it.command;
        mdl_count = '0;
        mdl_bits  = '0;
        case (it.command)
          CMD_START: begin
            mdl_sda  = 1'b1;
            mdl_scl  = 1'b1;
            mdl_step = ST_S1;
          end
          CMD_STOP: begin
            mdl_scl  = 1'b0;
            mdl_step = ST_P1;
          end
          CMD_WRITE: begin
            mdl_shift = it.write_byte;
            mdl_sda   = (it.write_byte & MSB_MASK) != 8'd0;
            mdl_scl   = 1'b1;
            mdl_step  = ST_WHI;
          end
          default: begin   // read
            mdl_shift = '0;
            mdl_ack   = it.send_ack;
            mdl_sda   = 1'b1;
            mdl_step  = ST_RPRE;
          end
        endcase
      end
    end else if (it.tick) begin
      mdl_count = mdl_count + 16'd1;
      if (mdl_count >= limit) begin
        mdl_count = '0;
        case (mdl_step)
          ST_S1: begin mdl_sda = 1'b0; mdl_step = ST_S2; end
          ST_S2: begin mdl_scl = 1'b0; mdl_step = ST_S3; end
          ST_S3: begin mdl_step = ST_IDLE; done = 1'b1; end
          ST_P1: begin mdl_sda = 1'b0; mdl_step = ST_P2; end
          ST_P2: begin mdl_scl = 1'b1; mdl_step = ST_P3; end
          ST_P3: begin mdl_sda = 1'b1; mdl_step = ST_IDLE; done = 1'b1; end
          ST_WHI: begin
            mdl_scl = 1'b0;
            if (mdl_bits == LAST_BIT) mdl_sda = 1'b1;
            mdl_shift = mdl_shift << 1;
            mdl_step  = ST_WLO;
          end
          ST_WLO: begin
            mdl_bits = mdl_bits + 4'd1;
            if (mdl_bits < BITS_PER_BYTE) begin
              mdl_sda  = (mdl_shift & MSB_MASK) != 8'd0;
              mdl_scl  = 1'b1;
              mdl_step = ST_WHI;
            end else begin
              mdl_sda  = 1'b1;
              mdl_step = ST_A1;
            end
          end
          ST_A1: begin mdl_scl = 1'b1; mdl_step = ST_A2; end
          ST_A2: begin
            mdl_nack = it.sda_in;
            mdl_scl  = 1'b0;
            mdl_step = ST_A3;
          end
          ST_A3: begin mdl_step = ST_IDLE; done = 1'b1; end
          ST_RPRE: begin mdl_scl = 1'b1; mdl_step = ST_RHI; end
          ST_RHI: begin
            mdl_shift = {mdl_shift[6:0], it.sda_in};
            mdl_scl   = 1'b0;
            mdl_step  = ST_RLO;
          end
          ST_RLO: begin
            mdl_bits = mdl_bits + 4'd1;
            if (mdl_bits < BITS_PER_BYTE) begin
              mdl_scl  = 1'b1;
              mdl_step = ST_RHI;
            end else begin
              mdl_step = ST_RGAP;
            end
          end
          ST_RGAP: begin mdl_sda = mdl_ack ? 1'b0 : 1'b1; mdl_step = ST_K1; end
          ST_K1: begin mdl_scl = 1'b1; mdl_step = ST_K2; end
          ST_K2: begin mdl_scl = 1'b0; mdl_step = ST_K3; end
          ST_K3: begin
            if (mdl_ack) mdl_sda = 1'b1;
            mdl_rd_hold = mdl_shift;
            mdl_step    = ST_IDLE;
            done        = 1'b1;
          end
          default: mdl_step = ST_IDLE;   // stray step: back to idle, no done
        endcase
      end
    end
    r.scl_level = mdl_scl;
    r.sda_level = mdl_sda;
    r.ready_res = (mdl_step == ST_IDLE);
    r.done_res  = done;
    r.read_data = mdl_rd_hold;
    r.nack_seen = mdl_nack;
  endtask

  // Offers one item after a random gap; predicts its result once accepted.
  // Returns at the accepting edge with item_valid still high.
  task automatic offer_item(input in_item_t it);
    res_item_t want;
    @(negedge clk);
    while ($urandom_range(99) < tx_gap_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    if (it.command_valid) begin
      if (mdl_step == ST_IDLE) cmd_count[it.command]++;
      else busy_cmds++;
    end
    step_line_model(it, want);
    expected_lines.push_back(want);
    items_sent++;
  endtask

  function automatic in_item_t tick_item(input int tick_pct, input int noise_pct,
                                         input sda_mode_e sm);
    in_item_t it;
    it.tick          = ($urandom_range(99) < tick_pct);
    it.command_valid = ($urandom_range(99) < noise_pct);
    it.command       = 2'($urandom_range(3));
    it.write_byte    = 8'($urandom_range(255));
    it.send_ack      = 1'($urandom_range(1));
    case (sm)
      SDA_LOW:  it.sda_in = 1'b0;
      SDA_HIGH: it.sda_in = 1'b1;
      default:  it.sda_in = 1'($urandom_range(1));
    endcase
    return it;
  endfunction

  // One command, then ticks until the model says it is back to idle
  task automatic run_command(input logic [1:0] cmd, input logic [7:0] wb, input logic ack,
                             input sda_mode_e sm, input int tick_pct, input int noise_pct);
    in_item_t it;
    it               = tick_item(50, 0, sm);   // accept ignores tick
    it.command_valid = 1'b1;
    it.command       = cmd;
    it.write_byte    = wb;
    it.send_ack      = ack;
    offer_item(it);
    while (mdl_step != ST_IDLE) offer_item(tick_item(tick_pct, noise_pct, sm));
  endtask

  // Finish any command in progress, then wait for every result to come out
  task automatic settle();
    while (mdl_step != ST_IDLE) offer_item(tick_item(100, 0, SDA_RANDOM));
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
  endtask

  // phase_ticks only changes with the sequencer idle and the pipe empty
  task automatic reconfigure(input logic [15:0] ticks);
    settle();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= ticks;
    @(negedge clk);
    cfg_we    <= 1'b0;
    mdl_ticks  = ticks;
  endtask

  // Random traffic: mostly start / 1-4 byte transfers / stop transactions,
  // with some out-of-order commands, idle slots and commands while busy.
  task automatic drive_traffic(input int n);
    in_item_t it;
    int       count;
    bit       in_txn;
    int       txn_len;
    count   = 0;
    in_txn  = 1'b0;
    txn_len = 0;
    while (count < n) begin
      if (mdl_step == ST_IDLE) begin
        it = tick_item(50, 0, SDA_RANDOM);
        if ($urandom_range(99) >= 10) begin
          it.command_valid = 1'b1;
          if ($urandom_range(99) < 10) it.command = 2'($urandom_range(3));
          else if (!in_txn) it.command = CMD_START;
          else if (txn_len == 0) it.command = CMD_STOP;
          else it.command = $urandom_range(1) ? CMD_WRITE : CMD_READ;
          case (it.command)
            CMD_START: begin in_txn = 1'b1; txn_len = $urandom_range(1, 4); end
            CMD_STOP:  in_txn = 1'b0;
            default:   if (txn_len > 0) txn_len--;
          endcase
        end
      end else begin
        it = tick_item(85, 15, SDA_RANDOM);
      end
      offer_item(it);
      count++;
    end
  endtask

  // ---- tests ----

  // Idle bus after reset; ticks while idle change nothing
  task automatic test_idle_bus();
    repeat (6) offer_item(tick_item(50, 0, SDA_RANDOM));
  endtask

  // Each command at the reset phase_ticks; ack/nack both ways, read 0xFF and
  // 0x00, ignored commands while busy and tick gaps mid-command
  task automatic test_each_command();
    run_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 100, 0);
    run_command(CMD_WRITE, 8'hFF, 1'b0, SDA_LOW, 100, 0);
    run_command(CMD_WRITE, 8'h00, 1'b1, SDA_HIGH, 100, 0);
    run_command(CMD_WRITE, 8'hA5, 1'b1, SDA_RANDOM, 60, 30);
    run_command(CMD_READ, 8'h00, 1'b1, SDA_HIGH, 100, 0);
    run_command(CMD_READ, 8'hFF, 1'b0, SDA_LOW, 100, 0);
    run_command(CMD_READ, 8'h5A, 1'b1, SDA_RANDOM, 70, 40);
    run_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 100, 20);
  endtask

  // Short phase settings, zero among them
  task automatic test_phase_ticks_range();
    logic [15:0] settings [4];
    settings[0] = 16'd0;
    settings[1] = 16'd1;
    settings[2] = 16'd3;
    settings[3] = 16'd7;
    foreach (settings[i]) begin
      reconfigure(settings[i]);
      run_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 80, 10);
      run_command(CMD_WRITE, 8'($urandom_range(255)), 1'b0, SDA_RANDOM, 80, 10);
      run_command(CMD_READ, 8'h00, 1'($urandom_range(1)), SDA_RANDOM, 80, 10);
      run_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 80, 10);
    end
  endtask

  // Longer phase: one start, three phases of 40 ticks each
  task automatic test_longest_phase();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    reconfigure(16'd40);
    run_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 100, 2);
  endtask

  task automatic test_random_traffic(input int n, input int gap, input int stall);
    tx_gap_pct   = gap;
    rx_stall_pct = stall;
    reconfigure($urandom_range(99) < 15 ? 16'd0 : 16'($urandom_range(1, 3)));
    drive_traffic(n);
  endtask

  // Output held off for a long stretch while items keep coming: the
  // internal queue fills and item_ready has to drop
  task automatic test_backpressure();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    reconfigure(16'd1);
    @(posedge clk);
    hold_req = 150;
    drive_traffic(80);
  endtask

  // ---- result side ----

  initial begin : result_sink
    int hold_left;
    hold_left    = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_item_t want;
    if (!rst) begin
      if (item_valid && !item_ready) in_stall_cycles++;
      if (result_valid && result_ready) begin
        results_checked++;
        if (expected_lines.size() == 0) begin
          report_mismatch("unexpected result", int'(result), 0);
        end else begin
          want = expected_lines.pop_front();
          if (result.scl_level !== want.scl_level)
            report_mismatch("scl_level", int'(result.scl_level), int'(want.scl_level));
          if (result.sda_level !== want.sda_level)
            report_mismatch("sda_level", int'(result.sda_level), int'(want.sda_level));
          if (result.ready_res !== want.ready_res)
            report_mismatch("ready_res", int'(result.ready_res), int'(want.ready_res));
          if (result.done_res !== want.done_res)
            report_mismatch("done_res", int'(result.done_res), int'(want.done_res));
          if (result.read_data !== want.read_data)
            report_mismatch("read_data", int'(result.read_data), int'(want.read_data));
          if (result.nack_seen !== want.nack_seen)
            report_mismatch("nack_seen", int'(result.nack_seen), int'(want.nack_seen));
        end
      end
    end
  end

  // ---- sequence ----

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    hold_req     = 0;

    // model matches the post-reset engine: idle, lines released
    mdl_step    = ST_IDLE;
    mdl_count   = '0;
    mdl_bits    = '0;
    mdl_shift   = '0;
    mdl_cmd     = CMD_START;
    mdl_ack     = 1'b0;
    mdl_nack    = 1'b0;
    mdl_scl     = 1'b1;
    mdl_sda     = 1'b1;
    mdl_rd_hold = '0;
    mdl_ticks   = PHASE_TICKS_RST;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_bus();
    test_each_command();
    test_phase_ticks_range();
    test_longest_phase();
    test_random_traffic(160, 0, 0);
    test_random_traffic(160, 69, 0);
    test_random_traffic(160, 0, 69);
    test_random_traffic(160, 9, 9);
    test_backpressure();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_lines.size() != 0)
      report_mismatch("results never delivered", expected_lines.size(), 0);

    $display("Ran %0d items, checked %0d results: %0d start, %0d stop, %0d write, %0d read,",
             items_sent, results_checked, cmd_count[CMD_START], cmd_count[CMD_STOP],
             cmd_count[CMD_WRITE], cmd_count[CMD_READ]);
    $display("%0d commands ignored while busy, phase_ticks 0..40, %0d input stall cycles.",
             busy_cmds, in_stall_cycles);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
